// ----- sv/bcta_pkg.sv -----
// shared constants, codes and types for the bounds-checked tensor access block
// no dependencies
package bcta_pkg;

    localparam int CFG_W       = 13;
    localparam int PLANE_W     = 2 * CFG_W;
    localparam int IDX_W       = 32;
    localparam int DATA_W      = 64;
    localparam int RANK_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int REG_IDX_W   = 2;
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [RANK_W-1:0] RANK_LINEAR = 2'd1;
    localparam logic [RANK_W-1:0] RANK_MATRIX = 2'd2;
    localparam logic [RANK_W-1:0] RANK_CUBE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RD_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WR_OOB  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

    // shape registers plus the values derived from them
    typedef struct packed {
        logic [CFG_W-1:0] element_count;
        logic [CFG_W-1:0] row_count;
        logic [CFG_W-1:0] column_count;
        logic [CFG_W-1:0] columns;
        logic [CFG_W-1:0] pages;
        logic [CFG_W-1:0] plane_lo;
    } shape_t;

endpackage

// ----- sv/bounds_checked_tensor_access.sv -----
// bounds-checked column-major tensor element access, top level
// done rises once an accepted access has passed the s1, s2 and s3 register stages
// throughput: one word per cycle while busy is low; the store ram has one port and
// the access path is three register stages, so accesses never collide on an entry
// a mapped register write holds busy high while the 13-step divider derives
// column and page counts; reset zeroes the shape with busy low; the store is not cleared
module bounds_checked_tensor_access (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [bcta_pkg::RANK_W-1:0]     rank,
    input  logic signed [bcta_pkg::IDX_W-1:0] row_index,
    input  logic signed [bcta_pkg::IDX_W-1:0] col_index,
    input  logic signed [bcta_pkg::IDX_W-1:0] page_index,
    input  logic [bcta_pkg::DATA_W-1:0]     write_value,
    output logic                          done,
    output logic [bcta_pkg::DATA_W-1:0]     read_value,
    output logic [bcta_pkg::STATUS_W-1:0]   status,
    input  logic                          wr_en,
    input  logic [bcta_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [bcta_pkg::CFG_W-1:0]      wr_data
);
    import bcta_pkg::*;

    shape_t shape;

    // index is usable when 1 <= idx and idx - 1 fits the dimension width
    function automatic logic idx_ok(input logic [IDX_W-1:0] f);
        logic [IDX_W-1:0] dec;
        dec    = f - 1'b1;
        idx_ok = !f[IDX_W-1] && (f != '0) && (dec[IDX_W-1:CFG_W] == '0);
    endfunction

    function automatic logic [CFG_W-1:0] idx_zb(input logic [IDX_W-1:0] f);
        logic [IDX_W-1:0] dec;
        dec    = f - 1'b1;
        idx_zb = dec[CFG_W-1:0];
    endfunction

    logic               accept;

    // stage 1: decoded indices
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [RANK_W-1:0]  s1_rank_reg;
    logic               s1_rok_reg, s1_cok_reg, s1_pok_reg;
    logic [CFG_W-1:0]   s1_r_reg, s1_c_reg, s1_p_reg;
    logic [DATA_W-1:0]  s1_wv_reg;

    // stage 2: bounds result and address terms
    logic               s2_valid_reg;
    logic               s2_cmd_reg;
    logic               s2_ok_reg;
    logic [CFG_W-1:0]   s2_prod_c_reg, s2_prod_p_reg, s2_r_reg;
    logic [DATA_W-1:0]  s2_wv_reg;
    logic               s2_ok_next;
    logic [PLANE_W-1:0] prod_c_full, prod_p_full;
    logic [CFG_W-1:0]   s2_prod_c_next, s2_prod_p_next;

    // stage 3: store access
    logic               s3_valid_reg;
    logic               s3_cmd_reg;
    logic               s3_ok_reg;
    logic [CFG_W-1:0]   lin_addr;
    logic               in_store;
    logic               s3_ok_next;
    logic               ram_we;
    logic [DATA_W-1:0]  ram_rdata;

    bcta_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .shape    (shape),
        .busy     (busy)
    );

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= command;
        s1_rank_reg <= rank;
        s1_rok_reg  <= idx_ok(row_index);
        s1_cok_reg  <= idx_ok(col_index);
        s1_pok_reg  <= idx_ok(page_index);
        s1_r_reg    <= idx_zb(row_index);
        s1_c_reg    <= idx_zb(col_index);
        s1_p_reg    <= idx_zb(page_index);
        s1_wv_reg   <= write_value;
    end

    // address terms only matter when in bounds, and then the sum is below 2^13
    assign prod_c_full = s1_c_reg * shape.row_count;
    assign prod_p_full = s1_p_reg * shape.plane_lo;

    always_comb
    begin
        s2_ok_next     = 1'b0;
        s2_prod_c_next = '0;
        s2_prod_p_next = '0;
        case (s1_rank_reg)
            RANK_LINEAR:
            begin
                s2_ok_next = s1_rok_reg && (s1_r_reg < shape.element_count);
            end
            RANK_MATRIX:
            begin
                s2_ok_next     = s1_rok_reg && s1_cok_reg &&
                                 (s1_r_reg < shape.row_count) && (s1_c_reg < shape.columns);
                s2_prod_c_next = prod_c_full[CFG_W-1:0];
            end
            RANK_CUBE:
            begin
                s2_ok_next     = s1_rok_reg && s1_cok_reg && s1_pok_reg &&
                                 (s1_r_reg < shape.row_count) &&
                                 (s1_c_reg < shape.column_count) &&
                                 (s1_p_reg < shape.pages);
                s2_prod_c_next = prod_c_full[CFG_W-1:0];
                s2_prod_p_next = prod_p_full[CFG_W-1:0];
            end
            default:
            begin
                s2_ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg    <= s1_cmd_reg;
        s2_ok_reg     <= s2_ok_next;
        s2_prod_c_reg <= s2_prod_c_next;
        s2_prod_p_reg <= s2_prod_p_next;
        s2_r_reg      <= s1_r_reg;
        s2_wv_reg     <= s1_wv_reg;
    end

    assign lin_addr   = s2_prod_p_reg + s2_prod_c_reg + s2_r_reg;
    assign in_store   = ({{(32-CFG_W){1'b0}}, lin_addr} < 32'(STORE_DEPTH));
    assign s3_ok_next = s2_ok_reg && in_store;
    assign ram_we     = s2_valid_reg && s3_ok_next && (s2_cmd_reg == CMD_WRITE);

    bcta_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (s2_valid_reg),
        .we    (ram_we),
        .addr  (STORE_AW'(lin_addr)),
        .wdata (s2_wv_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        s3_cmd_reg <= s2_cmd_reg;
        s3_ok_reg  <= s3_ok_next;
    end

    assign done       = s3_valid_reg;
    assign read_value = (s3_ok_reg && s3_cmd_reg == CMD_READ) ? ram_rdata : '0;
    assign status     = s3_ok_reg ? STATUS_OK :
                        ((s3_cmd_reg == CMD_WRITE) ? STATUS_WR_OOB : STATUS_RD_OOB);

endmodule

// ----- sv/bcta_ram.sv -----
// generic single-port synchronous ram with registered read data
// no dependencies
module bcta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ----- sv/bcta_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on bcta_pkg
module bcta_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [bcta_pkg::CFG_W-1:0]   dividend,
    input  logic [bcta_pkg::PLANE_W-1:0] divisor,
    output logic [bcta_pkg::CFG_W-1:0]   quotient,
    output logic                       active
);
    import bcta_pkg::*;

    localparam int CNT_W = $clog2(CFG_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [PLANE_W-1:0] rem_reg;
    logic [CFG_W-1:0]   quo_reg;
    logic [PLANE_W-1:0] div_reg;
    logic [PLANE_W:0]   shifted;
    logic [PLANE_W:0]   diff;
    logic               fits;

    assign shifted  = {rem_reg, quo_reg[CFG_W-1]};
    assign diff     = shifted - {1'b0, div_reg};
    assign fits     = (shifted >= {1'b0, div_reg});
    assign quotient = quo_reg;
    assign active   = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= CNT_W'(CFG_W);
        end
        else if (active)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (active)
        begin
            rem_reg <= fits ? diff[PLANE_W-1:0] : shifted[PLANE_W-1:0];
            quo_reg <= {quo_reg[CFG_W-2:0], fits};
        end
    end

endmodule

// ----- sv/bcta_cfg.sv -----
// shape registers and derivation of column and page counts
// depends on bcta_pkg and bcta_div
module bcta_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [bcta_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [bcta_pkg::CFG_W-1:0]     wr_data,
    output bcta_pkg::shape_t             shape,
    output logic                         busy
);
    import bcta_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CFG_W-1:0]   elem_reg;
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_cfg_reg;
    logic [CFG_W-1:0]   columns_reg;
    logic [CFG_W-1:0]   pages_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic               reg_hit;
    logic               div_load;
    logic [CFG_W-1:0]   col_quo;
    logic [CFG_W-1:0]   page_quo;
    logic               col_active;
    logic               page_active;

    assign reg_hit  = wr_en && (wr_index == REG_ELEMENT_COUNT || wr_index == REG_ROW_COUNT ||
                                wr_index == REG_COLUMN_COUNT);
    assign div_load = (state_reg == ST_LOAD);
    assign busy     = (state_reg != ST_IDLE);

    bcta_div u_col_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (elem_reg),
        .divisor  ({{(PLANE_W-CFG_W){1'b0}}, rows_reg}),
        .quotient (col_quo),
        .active   (col_active)
    );

    bcta_div u_page_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (elem_reg),
        .divisor  (plane_reg),
        .quotient (page_quo),
        .active   (page_active)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  state_next = (col_active || page_active) ? ST_DIV : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // a new write to a mapped shape register restarts the derivation
        if (reg_hit)
        begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            elem_reg     <= '0;
            rows_reg     <= '0;
            cols_cfg_reg <= '0;
            columns_reg  <= '0;
            pages_reg    <= '0;
            plane_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_ELEMENT_COUNT: elem_reg     <= wr_data;
                    REG_ROW_COUNT:     rows_reg     <= wr_data;
                    REG_COLUMN_COUNT:  cols_cfg_reg <= wr_data;
                    default:           ;
                endcase
            end
            if (state_reg == ST_MUL)
            begin
                plane_reg <= rows_reg * cols_cfg_reg;
            end
            if (state_reg == ST_DIV && !col_active && !page_active && !reg_hit)
            begin
                columns_reg <= (rows_reg != '0) ? col_quo : '0;
                pages_reg   <= (plane_reg != '0) ? page_quo : '0;
            end
        end
    end

    assign shape.element_count = elem_reg;
    assign shape.row_count     = rows_reg;
    assign shape.column_count  = cols_cfg_reg;
    assign shape.columns       = columns_reg;
    assign shape.pages         = pages_reg;
    assign shape.plane_lo      = plane_reg[CFG_W-1:0];

endmodule

// ----- sv/bcta_checker.sv -----
// port-level checks for the tensor access block, bound to the top level
// depends on bcta_pkg and bounds_checked_tensor_access
module bcta_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [bcta_pkg::DATA_W-1:0]     read_value,
    input logic [bcta_pkg::STATUS_W-1:0]   status,
    input logic                          wr_en,
    input logic [bcta_pkg::REG_IDX_W-1:0]  wr_index
);
    import bcta_pkg::*;

    // exactly one word out for each accepted word, with done matching a past accept
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |->
            (done == $past(start && !busy, 3)))
        else $error("result strobe does not match accepted words");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != STATUS_UNUSED))
        else $error("unused status code");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (read_value == '0))
        else $error("failed access returned data");

    a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (wr_index == REG_ELEMENT_COUNT || wr_index == REG_ROW_COUNT ||
                   wr_index == REG_COLUMN_COUNT)) |=> busy)
        else $error("register write did not start derivation");

endmodule

bind bounds_checked_tensor_access bcta_checker u_bcta_checker (.*);

// ----- verif/tb_bounds_checked_tensor_access.sv -----
`timescale 1ns / 100ps
// self-checking regression for the bounds-checked tensor access block
// depends on bcta_pkg and bounds_checked_tensor_access; an in-bench model of
// the shape registers and element store predicts every result word
module tb_bounds_checked_tensor_access;
    import bcta_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [RANK_W-1:0]    RANK_NONE    = 2'd0;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } access_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    command;
    logic [RANK_W-1:0]       rank;
    logic signed [IDX_W-1:0] row_index;
    logic signed [IDX_W-1:0] col_index;
    logic signed [IDX_W-1:0] page_index;
    logic [DATA_W-1:0]       write_value;
    logic                    done;
    logic [DATA_W-1:0]       read_value;
    logic [STATUS_W-1:0]     status;
    logic                    wr_en;
    logic [REG_IDX_W-1:0]    wr_index;
    logic [CFG_W-1:0]        wr_data;

    // model copy of the store and the shape
    logic [DATA_W-1:0] model_store [STORE_DEPTH];
    bit                model_written [STORE_DEPTH];
    int                written_addrs [$];
    logic [CFG_W-1:0]  shape_elements;
    logic [CFG_W-1:0]  shape_rows;
    logic [CFG_W-1:0]  shape_cols;
    logic [CFG_W-1:0]  shape_columns;
    logic [CFG_W-1:0]  shape_pages;

    access_result_t expected_results [$];
    int error_count;
    int cycle_count;
    int idle_pct;

    bounds_checked_tensor_access i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .rank        (rank),
        .row_index   (row_index),
        .col_index   (col_index),
        .page_index  (page_index),
        .write_value (write_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bounds_checked_tensor_access regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        access_result_t want;
        if (done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result word with no access pending", read_value, '0);
            else
            begin
                want = expected_results.pop_front();
                if (read_value !== want.value)
                    report_mismatch("read_value", read_value, want.value);
                if (status !== want.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
            end
        end
    end

    // bounds check and column-major address of one access under the current shape
    function automatic bit locate_element(input logic [RANK_W-1:0] rk,
                                          input logic signed [IDX_W-1:0] ri,
                                          input logic signed [IDX_W-1:0] ci,
                                          input logic signed [IDX_W-1:0] pi,
                                          output int addr);
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] p;
        logic [63:0] a;
        logic [63:0] plane;
        bit ok;
        // one unsigned compare rejects zero, negative and past-the-end indices
        r = {{32{ri[IDX_W-1]}}, ri} - 64'd1;
        c = {{32{ci[IDX_W-1]}}, ci} - 64'd1;
        p = {{32{pi[IDX_W-1]}}, pi} - 64'd1;
        plane = 64'(shape_rows) * 64'(shape_cols);
        ok = 1'b0;
        a = '0;
        case (rk)
            RANK_LINEAR:
            begin
                ok = r < 64'(shape_elements);
                a = r;
            end
            RANK_MATRIX:
            begin
                ok = shape_rows != 0 && r < 64'(shape_rows) && c < 64'(shape_columns);
                a = c * 64'(shape_rows) + r;
            end
            RANK_CUBE:
            begin
                ok = shape_rows != 0 && shape_cols != 0 && r < 64'(shape_rows) &&
                     c < 64'(shape_cols) && p < 64'(shape_pages);
                a = p * plane + c * 64'(shape_rows) + r;
            end
            default:
                ok = 1'b0;
        endcase
        if (ok && a >= 64'(STORE_DEPTH))
            ok = 1'b0;
        addr = ok ? int'(a) : 0;
        return ok;
    endfunction

    task automatic send_access(input logic cmd, input logic [RANK_W-1:0] rk,
                               input logic signed [IDX_W-1:0] ri,
                               input logic signed [IDX_W-1:0] ci,
                               input logic signed [IDX_W-1:0] pi,
                               input logic [DATA_W-1:0] wv);
        access_result_t res;
        int addr;
        bit ok;
        logic use_cmd;
        use_cmd = cmd;
        ok = locate_element(rk, ri, ci, pi, addr);
        // an entry never written holds nothing defined, so store to it instead
        if (ok && cmd == CMD_READ && !model_written[addr])
            use_cmd = CMD_WRITE;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        command     <= use_cmd;
        rank        <= rk;
        row_index   <= ri;
        col_index   <= ci;
        page_index  <= pi;
        write_value <= wv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res.value = '0;
        if (!ok)
            res.status = (use_cmd == CMD_WRITE) ? STATUS_WR_OOB : STATUS_RD_OOB;
        else if (use_cmd == CMD_WRITE)
        begin
            model_store[addr] = wv;
            if (!model_written[addr])
                written_addrs.push_back(addr);
            model_written[addr] = 1'b1;
            res.status = STATUS_OK;
        end
        else
        begin
            res.value = model_store[addr];
            res.status = STATUS_OK;
        end
        expected_results.push_back(res);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int plane;
        // let the derivation started by an earlier write show on busy, then finish
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_ELEMENT_COUNT: shape_elements = data;
            REG_ROW_COUNT:     shape_rows = data;
            REG_COLUMN_COUNT:  shape_cols = data;
            default:           return;
        endcase
        plane = int'(shape_rows) * int'(shape_cols);
        shape_columns = (shape_rows != 0) ? CFG_W'(int'(shape_elements) / int'(shape_rows)) : '0;
        shape_pages = (plane != 0) ? CFG_W'(int'(shape_elements) / plane) : '0;
    endtask

    task automatic apply_shape(input logic [CFG_W-1:0] elements, input logic [CFG_W-1:0] rows,
                               input logic [CFG_W-1:0] cols);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ELEMENT_COUNT, elements);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [IDX_W-1:0] pick_index(input int dim);
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(dim + 1, 1);
        if (roll < 90)
        begin
            case ($urandom_range(4))
                0:       return 0;
                1:       return -1;
                2:       return 32'h8000_0000;
                3:       return 32'h7fff_ffff;
                default: return dim;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_access();
        logic cmd;
        logic [RANK_W-1:0] rk;
        logic signed [IDX_W-1:0] ri;
        logic signed [IDX_W-1:0] ci;
        logic signed [IDX_W-1:0] pi;
        int a;
        int plane;
        int rows;
        cmd = $urandom_range(1);
        rk = ($urandom_range(99) < 5) ? RANK_NONE : RANK_W'($urandom_range(3, 1));
        ri = pick_index((rk == RANK_LINEAR) ? shape_elements : shape_rows);
        ci = pick_index((rk == RANK_CUBE) ? shape_cols : shape_columns);
        pi = pick_index(shape_pages);
        rows = int'(shape_rows);
        plane = rows * int'(shape_cols);
        // revisit a stored entry so reads land on defined data
        if (cmd == CMD_READ && written_addrs.size() != 0 && $urandom_range(99) < 40)
        begin
            a = written_addrs[$urandom_range(written_addrs.size() - 1)];
            if (rk == RANK_LINEAR)
                ri = a + 1;
            else if (rk == RANK_MATRIX && rows != 0)
            begin
                ri = a % rows + 1;
                ci = a / rows + 1;
            end
            else if (rk == RANK_CUBE && plane != 0)
            begin
                pi = a / plane + 1;
                ri = (a % plane) % rows + 1;
                ci = (a % plane) / rows + 1;
            end
        end
        send_access(cmd, rk, ri, ci, pi, {$urandom, $urandom});
    endtask

    task automatic test_reset_shape();
        send_access(CMD_READ, RANK_LINEAR, 1, 1, 1, '0);
        send_access(CMD_WRITE, RANK_MATRIX, 1, 1, 1, '1);
        send_access(CMD_WRITE, RANK_NONE, 1, 1, 1, '1);
    endtask

    task automatic test_ranks_and_commands();
        apply_shape(13'd24, 13'd4, 13'd3);
        send_access(CMD_WRITE, RANK_LINEAR, 1, 1, 1, '1);
        send_access(CMD_READ, RANK_LINEAR, 1, 1, 1, '0);
        send_access(CMD_WRITE, RANK_MATRIX, 4, 6, 1, 64'h0123_4567_89ab_cdef);
        // same entry seen as the last element of the second page
        send_access(CMD_READ, RANK_CUBE, 4, 3, 2, '0);
        send_access(CMD_WRITE, RANK_CUBE, 1, 1, 1, 64'h5a5a_a5a5_0ff0_f00f);
        send_access(CMD_READ, RANK_MATRIX, 1, 1, 1, '0);
        send_access(CMD_READ, RANK_MATRIX, 1, 7, 1, '0);
    endtask

    task automatic test_index_extremes();
        send_access(CMD_READ, RANK_LINEAR, 0, 1, 1, '0);
        send_access(CMD_WRITE, RANK_LINEAR, -1, 1, 1, '1);
        send_access(CMD_WRITE, RANK_LINEAR, 32'h8000_0000, 1, 1, '1);
        send_access(CMD_READ, RANK_LINEAR, 32'h7fff_ffff, 1, 1, '0);
        send_access(CMD_WRITE, RANK_LINEAR, 25, 1, 1, '1);
        send_access(CMD_WRITE, RANK_LINEAR, 24, 1, 1, '0);
        send_access(CMD_READ, RANK_NONE, 1, 1, 1, '0);
    endtask

    task automatic test_zero_dimensions();
        apply_shape(13'd100, 13'd0, 13'd5);
        send_access(CMD_READ, RANK_MATRIX, 1, 1, 1, '0);
        send_access(CMD_WRITE, RANK_CUBE, 1, 1, 1, '1);
        send_access(CMD_WRITE, RANK_LINEAR, 100, 1, 1, 64'h8000_0000_0000_0001);
        apply_shape(13'd60, 13'd5, 13'd0);
        send_access(CMD_READ, RANK_CUBE, 1, 1, 1, '0);
        send_access(CMD_WRITE, RANK_MATRIX, 5, 12, 1, 64'hdead_beef_cafe_f00d);
    endtask

    task automatic test_beyond_store();
        apply_shape(13'h1fff, 13'd1, 13'd1);
        send_access(CMD_WRITE, RANK_LINEAR, 4096, 1, 1, 64'hfedc_ba98_7654_3210);
        send_access(CMD_READ, RANK_LINEAR, 4097, 1, 1, '0);
        send_access(CMD_WRITE, RANK_MATRIX, 1, 4097, 1, '1);
        send_access(CMD_READ, RANK_CUBE, 1, 1, 4096, '0);
        apply_shape(13'h1fff, 13'h1fff, 13'h1fff);
        // the unmapped index must leave the shape alone
        write_reg(REG_UNMAPPED, '0);
        send_access(CMD_READ, RANK_MATRIX, 1, 1, 1, '0);
        send_access(CMD_READ, RANK_CUBE, 1, 1, 1, '0);
    endtask

    task automatic test_random_traffic(input int pct, input int count);
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(9))
                    0:
                        apply_shape(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                    1:
                        apply_shape(13'h1fff, CFG_W'($urandom_range(3, 1)),
                                    CFG_W'($urandom_range(3, 1)));
                    2:
                        apply_shape(CFG_W'($urandom_range(64)), '0, CFG_W'($urandom_range(8)));
                    3:
                    begin
                        apply_shape(CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(8, 1)),
                                    CFG_W'($urandom_range(8, 1)));
                        write_reg(REG_UNMAPPED, CFG_W'($urandom));
                    end
                    default:
                        apply_shape(CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(8, 1)),
                                    CFG_W'($urandom_range(8, 1)));
                endcase
            end
            else if (n == count / 2)
                wait_drained();
            random_access();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_READ;
        rank           = RANK_NONE;
        row_index      = '0;
        col_index      = '0;
        page_index     = '0;
        write_value    = '0;
        wr_en          = 1'b0;
        wr_index       = REG_ELEMENT_COUNT;
        wr_data        = '0;
        shape_elements = '0;
        shape_rows     = '0;
        shape_cols     = '0;
        shape_columns  = '0;
        shape_pages    = '0;
        error_count    = 0;
        idle_pct       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        test_reset_shape();
        test_ranks_and_commands();
        test_index_extremes();
        test_zero_dimensions();
        test_beyond_store();
        test_random_traffic(34, 200);
        test_random_traffic(46, 200);
        test_random_traffic(0, 200);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("bounds_checked_tensor_access regression: pass");
        else
            $display("bounds_checked_tensor_access regression: fail");
        $finish;
    end

endmodule
